// ===== design/hpf_pkg.sv =====
// shared types and constants of the histogram percentile finder
package hpf_pkg;

	localparam int SAMPLE_W = 16;
	localparam int RANK_W   = 19;
	localparam int POS_W    = 17;
	localparam int REQ_W    = 2;

	localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	// answer when the rank is never reached
	localparam logic [POS_W-1:0] VALUE_SPAN = 17'h10000;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ===== design/histogram_percentile_finder_unit.sv =====
// histogram percentile finder: bucket store, add pipeline, query walk and divider
//
// Input channel (in_valid / in_stall) carries one request per transaction:
// req_type selects add sample, percentile query or clear; sample_value is used
// by adds, target_rank by queries. Request code 3 is taken and ignored.
// Output channel (out_valid / out_stall) carries one position per query.
// Adds run at one transaction per cycle while the block is idle: the bucket
// count is read from the single-port-read memory, bumped with saturation in the
// next cycle and written back; a back-to-back add to the same bucket takes the
// value being written. A query walks the buckets one per cycle through the
// memory read port, checking each bucket's registered read data against the rank,
// up to the last bucket when the rank is never reached; a restoring divider then
// does the in-bucket interpolation, skipped for an empty bucket or an unreached
// rank; the result is then registered, and the input is held until it is loaded
// into the output register.
// Reset and a clear request both start a clearing pass that zeroes every
// bucket, during which in_stall is high.
// A stalled result stays in the output register; adds are still taken, and a
// further query finishes its walk and divide and then waits for the register.
module histogram_percentile_finder_unit #(
	parameter int BUCKET_SHIFT = 6,
	parameter int COUNT_WIDTH  = 19
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [hpf_pkg::REQ_W-1:0]    req_type,
	input  logic [hpf_pkg::SAMPLE_W-1:0] sample_value,
	input  logic [hpf_pkg::RANK_W-1:0]   target_rank,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [hpf_pkg::POS_W-1:0]    position
);

	localparam int IDX_W       = hpf_pkg::SAMPLE_W - BUCKET_SHIFT;
	localparam int NUM_BUCKETS = 1 << IDX_W;
	localparam int NUM_W       = COUNT_WIDTH + BUCKET_SHIFT;
	localparam int TOT_W       = COUNT_WIDTH + IDX_W;
	localparam int CMP_W       = ((TOT_W > hpf_pkg::RANK_W) ? TOT_W : hpf_pkg::RANK_W) + 1;
	localparam int DCNT_W      = $clog2(NUM_W + 1);
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [IDX_W-1:0]       LAST_IDX  = '1;

	hpf_pkg::state_t state_q, nxt_state;

	// bucket store
	logic [COUNT_WIDTH-1:0] counts_q [NUM_BUCKETS];
	logic [COUNT_WIDTH-1:0] rd_q;
	logic                   mem_we;
	logic [IDX_W-1:0]       mem_waddr;
	logic [IDX_W-1:0]       mem_raddr;
	logic [COUNT_WIDTH-1:0] mem_wdata;

	// add pipeline
	logic                   s1_vld, s2_vld;
	logic [IDX_W-1:0]       idx_s1, idx_s2;
	logic [COUNT_WIDTH-1:0] wdata_s2;
	logic [COUNT_WIDTH-1:0] add_cur;
	logic [COUNT_WIDTH-1:0] add_wdata;

	// clearing pass and walk
	logic [IDX_W-1:0]         sweep_q;
	logic [IDX_W:0]           walk_addr_q;
	logic                     walk_issue;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         rd_idx_s1;
	logic [hpf_pkg::RANK_W-1:0] rank_q;
	logic [TOT_W-1:0]         total_q;
	logic [CMP_W-1:0]         sum_w;
	logic [CMP_W-1:0]         diff_w;
	logic                     reached;
	logic [NUM_W-1:0]         frac_num;

	// divider
	logic [NUM_W-1:0]       num_q, quot_q, quot_nxt;
	logic [COUNT_WIDTH-1:0] div_q;
	logic [COUNT_WIDTH:0]   rem_q, rem_try, rem_nxt;
	logic                   fits;
	logic [DCNT_W-1:0]      dcnt_q;
	logic                   div_done;

	// result
	logic [hpf_pkg::POS_W-1:0] base_q, res_q, pos_q;
	logic                      out_valid_q;
	logic                      load_out;

	logic acc_add, acc_query, acc_clear;

	assign acc_add   = in_valid && !in_stall && (req_type == hpf_pkg::REQ_ADD);
	assign acc_query = in_valid && !in_stall && (req_type == hpf_pkg::REQ_QUERY);
	assign acc_clear = in_valid && !in_stall && (req_type == hpf_pkg::REQ_CLEAR);

	// read-modify-write: take the value written last cycle when it hits the same bucket
	assign add_cur   = (s2_vld && (idx_s2 == idx_s1)) ? wdata_s2 : rd_q;
	assign add_wdata = (add_cur == COUNT_MAX) ? add_cur : add_cur + COUNT_WIDTH'(1);

	// one write port shared by the add pipeline and the clearing pass
	assign mem_we    = s1_vld || (state_q == hpf_pkg::ST_CLEAR);
	assign mem_waddr = s1_vld ? idx_s1 : sweep_q;
	assign mem_wdata = s1_vld ? add_wdata : '0;
	assign mem_raddr = (state_q == hpf_pkg::ST_WALK) ? walk_addr_q[IDX_W-1:0]
	                                                 : sample_value[hpf_pkg::SAMPLE_W-1:BUCKET_SHIFT];

	always_ff @(posedge clk) begin
		if (mem_we)
			counts_q[mem_waddr] <= mem_wdata;
		rd_q <= counts_q[mem_raddr];
	end

	// walk: one bucket per cycle, running total against the rank
	assign walk_issue = (state_q == hpf_pkg::ST_WALK) && !walk_addr_q[IDX_W];
	assign sum_w      = CMP_W'(total_q) + CMP_W'(rd_q);
	assign reached    = sum_w >= CMP_W'(rank_q);
	assign diff_w     = CMP_W'(rank_q) - CMP_W'(total_q);
	// rank minus count below never exceeds the bucket count once reached
	assign frac_num   = NUM_W'(diff_w[COUNT_WIDTH-1:0]) << BUCKET_SHIFT;

	// restoring divider, one quotient bit per cycle
	assign rem_try  = {rem_q[COUNT_WIDTH-1:0], num_q[NUM_W-1]};
	assign fits     = rem_try >= {1'b0, div_q};
	assign rem_nxt  = fits ? rem_try - {1'b0, div_q} : rem_try;
	assign quot_nxt = {quot_q[NUM_W-2:0], fits};
	assign div_done = (state_q == hpf_pkg::ST_DIV) && (dcnt_q == DCNT_W'(NUM_W - 1));

	assign load_out = (state_q == hpf_pkg::ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= hpf_pkg::ST_CLEAR;
		else
			state_q <= nxt_state;
	end

	always_comb begin
		nxt_state = state_q;
		in_stall  = 1'b1;
		unique case (state_q)
			hpf_pkg::ST_CLEAR: begin
				if (sweep_q == LAST_IDX)
					nxt_state = hpf_pkg::ST_IDLE;
			end
			hpf_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					unique case (req_type)
						hpf_pkg::REQ_QUERY: nxt_state = hpf_pkg::ST_WALK;
						hpf_pkg::REQ_CLEAR: nxt_state = hpf_pkg::ST_CLEAR;
						default:            nxt_state = hpf_pkg::ST_IDLE;
					endcase
				end
			end
			hpf_pkg::ST_WALK: begin
				if (rd_vld_s1) begin
					if (reached)
						nxt_state = (rd_q == '0) ? hpf_pkg::ST_OUT : hpf_pkg::ST_DIV;
					else if (rd_idx_s1 == LAST_IDX)
						nxt_state = hpf_pkg::ST_OUT;
				end
			end
			hpf_pkg::ST_DIV: begin
				if (div_done)
					nxt_state = hpf_pkg::ST_OUT;
			end
			hpf_pkg::ST_OUT: begin
				if (!out_valid_q || !out_stall)
					nxt_state = hpf_pkg::ST_IDLE;
			end
			default: nxt_state = hpf_pkg::ST_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			walk_addr_q <= '0;
			rd_vld_s1   <= 1'b0;
			s1_vld      <= 1'b0;
			s2_vld      <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == hpf_pkg::ST_CLEAR)
				sweep_q <= sweep_q + IDX_W'(1);
			else if (acc_clear)
				sweep_q <= '0;
			if (acc_query)
				walk_addr_q <= '0;
			else if (walk_issue)
				walk_addr_q <= walk_addr_q + (IDX_W + 1)'(1);
			rd_vld_s1 <= walk_issue;
			s1_vld    <= acc_add;
			s2_vld    <= s1_vld;
			if (state_q == hpf_pkg::ST_WALK)
				dcnt_q <= '0;
			else if (state_q == hpf_pkg::ST_DIV)
				dcnt_q <= dcnt_q + DCNT_W'(1);
			if (load_out)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= walk_addr_q[IDX_W-1:0];
		idx_s1    <= sample_value[hpf_pkg::SAMPLE_W-1:BUCKET_SHIFT];
		idx_s2    <= idx_s1;
		wdata_s2  <= add_wdata;
		if (acc_query) begin
			rank_q  <= target_rank;
			total_q <= '0;
		end
		if ((state_q == hpf_pkg::ST_WALK) && rd_vld_s1) begin
			if (reached) begin
				num_q  <= frac_num;
				div_q  <= rd_q;
				rem_q  <= '0;
				quot_q <= '0;
				base_q <= hpf_pkg::POS_W'(rd_idx_s1) << BUCKET_SHIFT;
				// empty bucket: no interpolation, answer is the base
				res_q  <= hpf_pkg::POS_W'(rd_idx_s1) << BUCKET_SHIFT;
			end else begin
				total_q <= sum_w[TOT_W-1:0];
				res_q   <= hpf_pkg::VALUE_SPAN;
			end
		end
		if (state_q == hpf_pkg::ST_DIV) begin
			num_q  <= num_q << 1;
			rem_q  <= rem_nxt;
			quot_q <= quot_nxt;
			if (div_done)
				res_q <= base_q + hpf_pkg::POS_W'(quot_nxt[BUCKET_SHIFT:0]);
		end
		if (load_out)
			pos_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign position  = pos_q;

	// same-bucket forwarding must continue the count just written
	a_fwd_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld && s2_vld && (idx_s1 == idx_s2) && (wdata_s2 != COUNT_MAX))
		|-> (add_wdata == wdata_s2 + COUNT_WIDTH'(1)))
		else $error("forwarded bucket count not continued");

	// a waiting result is never overwritten by the next query
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hpf_pkg::ST_OUT && out_valid_q && out_stall)
		|=> (state_q == hpf_pkg::ST_OUT && out_valid_q))
		else $error("result register overwritten while stalled");

	// adds only enter from idle
	a_add_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld |-> ($past(state_q) == hpf_pkg::ST_IDLE))
		else $error("add pipeline loaded outside idle");

	// the walk reads a settled store
	a_walk_nowr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == hpf_pkg::ST_WALK) |-> !mem_we)
		else $error("bucket store written during walk");

	// interpolation stays inside the bucket
	a_frac_rng: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (quot_nxt <= (NUM_W'(1) << BUCKET_SHIFT)))
		else $error("interpolation beyond bucket width");

endmodule

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the histogram percentile finder unit
`timescale 1ns / 100ps

module testbench;

	// histogram geometry of the default build
	localparam int BUCKET_SHIFT = 6;
	localparam int COUNT_WIDTH  = 19;
	localparam int NUM_BUCKETS  = 1 << (hpf_pkg::SAMPLE_W - BUCKET_SHIFT);
	localparam int COUNT_MAX    = (1 << COUNT_WIDTH) - 1;

	// request code the block takes and drops
	localparam logic [hpf_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS = 850;
	// burst of adds into the top bucket at full rate
	localparam int BURST_ADDS   = 40;
	// a clearing pass, with margin
	localparam int TAIL_CYCLES  = 1100;
	// worst quiet stretch is a full bucket walk and divide
	localparam int QUIET_LIMIT  = 20000;

	// one row of the directed table; pinned rows carry a typed-in position
	typedef struct packed {
		logic [hpf_pkg::REQ_W-1:0]    req;
		logic [hpf_pkg::SAMPLE_W-1:0] smp;
		logic [hpf_pkg::RANK_W-1:0]   rank;
		logic                         pinned;
		logic [hpf_pkg::POS_W-1:0]    pos;
	} stim_row_t;

	localparam int SCRIPT_LEN = 25;
	localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
		// empty store after reset: rank 0 stops at empty bucket 0
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd0,     1'b1, 17'd0},
		// empty store: rank never reached
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd1,     1'b1, hpf_pkg::VALUE_SPAN},
		'{hpf_pkg::REQ_QUERY, 16'hFFFF, 19'h7FFFF, 1'b1, hpf_pkg::VALUE_SPAN},
		// lowest sample, then top of the same bucket as the next request
		'{hpf_pkg::REQ_ADD,   16'h0000, 19'h7FFFF, 1'b0, 17'd0},
		'{hpf_pkg::REQ_ADD,   16'h003F, 19'd0,     1'b0, 17'd0},
		'{hpf_pkg::REQ_ADD,   16'hFFFF, 19'd0,     1'b0, 17'd0},
		'{hpf_pkg::REQ_ADD,   16'h0040, 19'd0,     1'b0, 17'd0},
		// rank 0 on a filled bucket 0 gives its base
		'{hpf_pkg::REQ_QUERY, 16'hFFFF, 19'd0,     1'b1, 17'd0},
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd2,     1'b0, 17'd0},
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd3,     1'b0, 17'd0},
		// lands in the top bucket, interpolation reaches the span
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd4,     1'b0, 17'd0},
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd5,     1'b1, hpf_pkg::VALUE_SPAN},
		// unused code must leave the store alone
		'{REQ_UNUSED,         16'hAAAA, 19'h55555, 1'b0, 17'd0},
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd3,     1'b0, 17'd0},
		'{hpf_pkg::REQ_ADD,   16'h8000, 19'd0,     1'b0, 17'd0},
		'{hpf_pkg::REQ_ADD,   16'h7FFF, 19'd0,     1'b0, 17'd0},
		'{hpf_pkg::REQ_ADD,   16'h5555, 19'd0,     1'b0, 17'd0},
		'{hpf_pkg::REQ_ADD,   16'hAAAA, 19'd0,     1'b0, 17'd0},
		'{hpf_pkg::REQ_QUERY, 16'h5555, 19'h2AAAA, 1'b0, 17'd0},
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd6,     1'b0, 17'd0},
		'{hpf_pkg::REQ_CLEAR, 16'hFFFF, 19'h7FFFF, 1'b0, 17'd0},
		'{hpf_pkg::REQ_ADD,   16'h5555, 19'd0,     1'b0, 17'd0},
		// bucket 0 is empty again, rank 0 still stops there
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd0,     1'b1, 17'd0},
		'{hpf_pkg::REQ_QUERY, 16'h0000, 19'd1,     1'b0, 17'd0},
		'{hpf_pkg::REQ_CLEAR, 16'h0000, 19'd0,     1'b0, 17'd0}
	};

	logic                         clk;
	logic                         arst_n       = 1'b0;
	logic                         in_valid     = 1'b0;
	logic                         in_stall;
	logic [hpf_pkg::REQ_W-1:0]    req_type     = hpf_pkg::REQ_ADD;
	logic [hpf_pkg::SAMPLE_W-1:0] sample_value = '0;
	logic [hpf_pkg::RANK_W-1:0]   target_rank  = '0;
	logic                         out_valid;
	logic                         out_stall    = 1'b0;
	logic [hpf_pkg::POS_W-1:0]    position;

	// shadow histogram and the positions still owed by the block
	logic [COUNT_WIDTH-1:0]       bucket_tally [NUM_BUCKETS];
	logic [hpf_pkg::POS_W-1:0]    positions_due [$];
	logic [hpf_pkg::SAMPLE_W-1:0] hot_values [4];

	// no random idling on either side while set
	logic calm = 1'b0;

	int mismatches   = 0;
	int n_checked    = 0;
	int n_adds       = 0;
	int n_full_adds  = 0;
	int n_queries    = 0;
	int n_clears     = 0;
	int n_ignored    = 0;
	int quiet_cycles = 0;

	histogram_percentile_finder_unit #(
		.BUCKET_SHIFT(BUCKET_SHIFT),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.sample_value(sample_value),
		.target_rank (target_rank),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.position    (position)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// walk the buckets upward until the running total covers the rank
	function automatic logic [hpf_pkg::POS_W-1:0] percentile_of(
			input logic [hpf_pkg::RANK_W-1:0] rank);
		longint unsigned running;
		longint unsigned below;
		longint unsigned frac;
		running = 0;
		for (int b = 0; b < NUM_BUCKETS; b++) begin
			below = running;
			running += bucket_tally[b];
			if (running >= rank) begin
				// an empty bucket adds nothing inside
				frac = (bucket_tally[b] == 0) ? 0 :
					((longint'(rank) - below) << BUCKET_SHIFT) / bucket_tally[b];
				return hpf_pkg::POS_W'((longint'(b) << BUCKET_SHIFT) + frac);
			end
		end
		return hpf_pkg::VALUE_SPAN;
	endfunction

	function automatic longint unsigned stored_total();
		longint unsigned sum;
		sum = 0;
		for (int b = 0; b < NUM_BUCKETS; b++)
			sum += bucket_tally[b];
		return sum;
	endfunction

	// apply one taken request to the shadow histogram, return the position for queries
	function automatic logic [hpf_pkg::POS_W-1:0] track_request(
			input logic [hpf_pkg::REQ_W-1:0] req,
			input logic [hpf_pkg::SAMPLE_W-1:0] smp,
			input logic [hpf_pkg::RANK_W-1:0] rank);
		int idx;
		idx = smp >> BUCKET_SHIFT;
		case (req)
			hpf_pkg::REQ_ADD: begin
				n_adds++;
				// counts hold at their maximum
				if (bucket_tally[idx] == COUNT_MAX)
					n_full_adds++;
				else
					bucket_tally[idx]++;
			end
			hpf_pkg::REQ_QUERY: begin
				n_queries++;
				return percentile_of(rank);
			end
			hpf_pkg::REQ_CLEAR: begin
				n_clears++;
				foreach (bucket_tally[b])
					bucket_tally[b] = '0;
			end
			default: n_ignored++;
		endcase
		return '0;
	endfunction

	// drive one transaction at the falling edge, hold it until taken
	task automatic issue_request(input logic [hpf_pkg::REQ_W-1:0] req,
			input logic [hpf_pkg::SAMPLE_W-1:0] smp,
			input logic [hpf_pkg::RANK_W-1:0] rank, input logic pinned,
			input logic [hpf_pkg::POS_W-1:0] pin_pos);
		logic [hpf_pkg::POS_W-1:0] due;
		// random idle cycles with junk on the payload
		while (!calm && $urandom_range(99) < 29) begin
			in_valid     <= 1'b0;
			req_type     <= hpf_pkg::REQ_W'($urandom);
			sample_value <= hpf_pkg::SAMPLE_W'($urandom);
			target_rank  <= hpf_pkg::RANK_W'($urandom);
			@(negedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= req;
		sample_value <= smp;
		target_rank  <= rank;
		do
			@(posedge clk);
		while (in_stall);
		due = track_request(req, smp, rank);
		if (req == hpf_pkg::REQ_QUERY)
			positions_due.push_back(pinned ? pin_pos : due);
		@(negedge clk);
	endtask

	task automatic shuffle_hot_values();
		foreach (hot_values[i])
			hot_values[i] = hpf_pkg::SAMPLE_W'($urandom);
	endtask

	// rank mostly inside the stored total, some at its edge, some anywhere
	function automatic logic [hpf_pkg::RANK_W-1:0] pick_rank();
		longint unsigned tot;
		int r;
		tot = stored_total();
		r = $urandom_range(99);
		if (r < 60)
			return hpf_pkg::RANK_W'($urandom_range(int'(tot)));
		else if (r < 75)
			return hpf_pkg::RANK_W'(tot + $urandom_range(2));
		else if (r < 85)
			return '0;
		return hpf_pkg::RANK_W'($urandom);
	endfunction

	// result side: random stall at the falling edge
	initial begin
		forever begin
			@(negedge clk);
			out_stall <= !calm && ($urandom_range(99) < 29);
		end
	end

	// every taken position against the oldest one owed
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (positions_due.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: position %0d with no query waiting", $realtime, position);
				mismatches++;
			end else begin
				logic [hpf_pkg::POS_W-1:0] want;
				want = positions_due.pop_front();
				n_checked++;
				if (position !== want) begin
					if (mismatches < 10)
						$display("%0t: position expected %0d got %0d", $realtime, want, position);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: %0d cycles without a transaction", quiet_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		int counted;
		int r;
		logic [hpf_pkg::SAMPLE_W-1:0] smp;

		foreach (bucket_tally[b])
			bucket_tally[b] = '0;

		// reset held, then released at a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table: extremes, every request code, empty and unreached cases
		for (int i = 0; i < SCRIPT_LEN; i++)
			issue_request(SCRIPT[i].req, SCRIPT[i].smp, SCRIPT[i].rank,
				SCRIPT[i].pinned, SCRIPT[i].pos);

		// burst of adds into the top bucket at full rate, then probe it
		calm = 1'b1;
		for (int i = 0; i < BURST_ADDS; i++)
			issue_request(hpf_pkg::REQ_ADD,
				16'hFFC0 | hpf_pkg::SAMPLE_W'($urandom_range(63)), '0, 1'b0, '0);
		issue_request(hpf_pkg::REQ_QUERY, 16'h0000, 19'h7FFFF, 1'b0, '0);
		issue_request(hpf_pkg::REQ_QUERY, 16'h0000, 19'h40000, 1'b0, '0);
		issue_request(hpf_pkg::REQ_ADD, 16'h0000, 19'd0, 1'b0, '0);
		issue_request(hpf_pkg::REQ_QUERY, 16'h0000, 19'h7FFFF, 1'b0, '0);
		issue_request(hpf_pkg::REQ_QUERY, 16'h0000, 19'd0, 1'b0, '0);
		issue_request(hpf_pkg::REQ_CLEAR, 16'h0000, 19'd0, 1'b0, '0);
		calm = 1'b0;

		// random part: mostly adds into a few hot buckets, queries over the stored total
		shuffle_hot_values();
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			// a stretch with no idling in the middle
			calm = (counted >= 400 && counted < 550);
			r = $urandom_range(99);
			if (r < 78) begin
				if ($urandom_range(99) < 55)
					smp = hot_values[$urandom_range(3)]
						^ hpf_pkg::SAMPLE_W'($urandom_range(63));
				else
					smp = hpf_pkg::SAMPLE_W'($urandom);
				issue_request(hpf_pkg::REQ_ADD, smp, hpf_pkg::RANK_W'($urandom), 1'b0, '0);
				counted++;
			end else if (r < 91) begin
				issue_request(hpf_pkg::REQ_QUERY, hpf_pkg::SAMPLE_W'($urandom), pick_rank(),
					1'b0, '0);
				counted++;
			end else if (r < 93) begin
				issue_request(hpf_pkg::REQ_CLEAR, hpf_pkg::SAMPLE_W'($urandom),
					hpf_pkg::RANK_W'($urandom), 1'b0, '0);
				shuffle_hot_values();
				counted++;
			end else begin
				issue_request(REQ_UNUSED, hpf_pkg::SAMPLE_W'($urandom),
					hpf_pkg::RANK_W'($urandom), 1'b0, '0);
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// drain owed positions, then watch for strays through a clear pass
		while (positions_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (positions_due.size() != 0) begin
			$display("%0d positions never arrived", positions_due.size());
			mismatches += positions_due.size();
		end

		$display("requests taken: %0d adds (%0d on a full bucket), %0d queries,",
			n_adds, n_full_adds, n_queries);
		$display("  %0d clears, %0d ignored; positions checked: %0d, mismatches: %0d",
			n_clears, n_ignored, n_checked, mismatches);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
design/hpf_pkg.sv
design/histogram_percentile_finder_unit.sv
tb/sv/testbench.sv
